// ===== rtl/core/eti_pkg.sv =====
// ----------------------------------------------------------------------------
// eti_pkg
// Shared types and constants of the escape-time iterator: the microcode
// control word, datapath status and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package eti_pkg;

	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DATA_BITS = 32;
	localparam int POINT_BITS = 32;
	localparam int LIMIT_CFG_BITS = 16;
	localparam int MAX_ITER_RESET = 255;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_JULIA_MODE = 8'd0;
	localparam cfg_idx_t CFG_JULIA_C_RE = 8'd1;
	localparam cfg_idx_t CFG_JULIA_C_IM = 8'd2;
	localparam cfg_idx_t CFG_MAX_ITER   = 8'd3;

	// Microprogram step addresses.
	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT  = 3'd0;
	localparam step_t STEP_TEST  = 3'd1;
	localparam step_t STEP_MXY   = 3'd2;
	localparam step_t STEP_MYY   = 3'd3;
	localparam step_t STEP_PREP  = 3'd4;
	localparam step_t STEP_STEP  = 3'd5;
	localparam step_t STEP_EMIT  = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_MXX,
		OP_MXY,
		OP_MYY,
		OP_PREP,
		OP_STEP,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_STOP,
		BR_ESCAPE,
		BR_ALWAYS,
		BR_WAIT_OUT
	} br_t;

	typedef struct packed {
		dp_op_t op;
		br_t    br;
		step_t  target;
	} ctl_word_t;

	typedef struct packed {
		logic stop;
		logic escape;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/escape_time_iterator.sv =====
// Each iteration is five microcode steps, set by the one shared multiplier
// forming x*x, x*y and y*y in turn. One point is in work at a time: a new
// point is accepted only in the wait step, after the last count is emitted.
// Asynchronous active-low reset returns the sequencer to its wait step, drops
// the output, and sets the registers to Mandelbrot mode, c = 0, limit 255.
// ----------------------------------------------------------------------------
// escape_time_iterator
// Mandelbrot / Julia escape-time counter on signed fixed-point points, run
// by a small microprogram over a shared-multiplier datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_iterator #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS = 28
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    point_re,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    point_im,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic       [COUNT_BITS-1:0]             iteration_count,
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire        [eti_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire        [eti_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	eti_pkg::step_t pc;
	eti_pkg::ctl_word_t ctl;
	eti_pkg::dp_status_t status;

	logic julia_mode_q;
	logic signed [eti_pkg::POINT_BITS-1:0] julia_c_re_q, julia_c_im_q;
	logic [COUNT_BITS-1:0] max_iter_q;
	logic out_valid_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] n;
	logic in_fire, slot_free, emit;

	assign cfg_ready = 1'b1;
	assign in_stall = (ctl.br != eti_pkg::BR_WAIT_IN);
	assign in_fire = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit = (ctl.op == eti_pkg::OP_EMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_mode_q <= 1'b0;
			julia_c_re_q <= '0;
			julia_c_im_q <= '0;
			max_iter_q   <= COUNT_BITS'(eti_pkg::MAX_ITER_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				eti_pkg::CFG_JULIA_MODE: julia_mode_q <= cfg_data[0];
				eti_pkg::CFG_JULIA_C_RE: julia_c_re_q <= cfg_data;
				eti_pkg::CFG_JULIA_C_IM: julia_c_im_q <= cfg_data;
				eti_pkg::CFG_MAX_ITER:
					max_iter_q <= COUNT_BITS'(cfg_data[eti_pkg::LIMIT_CFG_BITS-1:0]);
				default: begin
				end
			endcase
		end
	end

	eti_ucode_rom u_rom (
		.pc  (pc),
		.ctl (ctl)
	);

	eti_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.status    (status),
		.in_valid  (in_valid),
		.slot_free (slot_free),
		.pc        (pc)
	);

	eti_datapath #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (ctl.op),
		.load           (in_fire),
		.point_re       (point_re),
		.point_im       (point_im),
		.julia_mode     (julia_mode_q),
		.julia_c_re     (julia_c_re_q),
		.julia_c_im     (julia_c_im_q),
		.max_iterations (max_iter_q),
		.status         (status),
		.count          (n)
	);

	// Output register: the count of a finished point waits here while the
	// sequencer goes back to take the next transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			count_q <= n;
		end
	end

	assign out_valid = out_valid_q;
	assign iteration_count = count_q;

	a_accept_starts_test: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (pc == eti_pkg::STEP_TEST))
		else $error("accepted point did not start the iteration loop");

	a_step_counts_one: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == eti_pkg::OP_STEP) |=> (n == $past(n) + 1'b1))
		else $error("iteration count did not advance by one on an update step");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.op == eti_pkg::OP_EMIT))
		else $error("result appeared outside the emit step");

endmodule

`default_nettype wire

// ===== rtl/core/eti_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// eti_ucode_rom
// Read-only control store: one control word for each microprogram step.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_ucode_rom (
	input  wire eti_pkg::step_t     pc,
	output eti_pkg::ctl_word_t      ctl
);

	// One iteration runs TEST, MXY, MYY, PREP and STEP; the squares and the
	// cross product share one multiplier.
	always_comb begin
		unique case (pc)
			eti_pkg::STEP_WAIT: begin
				ctl = '{eti_pkg::OP_LOAD, eti_pkg::BR_WAIT_IN, eti_pkg::STEP_TEST};
			end
			eti_pkg::STEP_TEST: begin
				ctl = '{eti_pkg::OP_MXX, eti_pkg::BR_STOP, eti_pkg::STEP_EMIT};
			end
			eti_pkg::STEP_MXY: begin
				ctl = '{eti_pkg::OP_MXY, eti_pkg::BR_NEXT, eti_pkg::STEP_MYY};
			end
			eti_pkg::STEP_MYY: begin
				ctl = '{eti_pkg::OP_MYY, eti_pkg::BR_NEXT, eti_pkg::STEP_PREP};
			end
			eti_pkg::STEP_PREP: begin
				ctl = '{eti_pkg::OP_PREP, eti_pkg::BR_ESCAPE, eti_pkg::STEP_EMIT};
			end
			eti_pkg::STEP_STEP: begin
				ctl = '{eti_pkg::OP_STEP, eti_pkg::BR_ALWAYS, eti_pkg::STEP_TEST};
			end
			eti_pkg::STEP_EMIT: begin
				ctl = '{eti_pkg::OP_EMIT, eti_pkg::BR_WAIT_OUT, eti_pkg::STEP_WAIT};
			end
			default: begin
				ctl = '{eti_pkg::OP_NOP, eti_pkg::BR_ALWAYS, eti_pkg::STEP_WAIT};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/eti_sequencer.sv =====
// ----------------------------------------------------------------------------
// eti_sequencer
// Step counter of the microprogram with its conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_sequencer (
	input  wire                     clk,
	input  wire                     arst_n,
	input  eti_pkg::ctl_word_t      ctl,
	input  eti_pkg::dp_status_t     status,
	input  wire                     in_valid,
	input  wire                     slot_free,
	output eti_pkg::step_t          pc
);

	eti_pkg::step_t pc_q;
	eti_pkg::step_t pc_next;
	eti_pkg::step_t pc_inc;

	assign pc_inc = pc_q + 3'd1;

	always_comb begin
		unique case (ctl.br)
			eti_pkg::BR_NEXT:     pc_next = pc_inc;
			eti_pkg::BR_WAIT_IN:  pc_next = in_valid ? pc_inc : pc_q;
			eti_pkg::BR_STOP:     pc_next = status.stop ? ctl.target : pc_inc;
			eti_pkg::BR_ESCAPE:   pc_next = status.escape ? ctl.target : pc_inc;
			eti_pkg::BR_ALWAYS:   pc_next = ctl.target;
			eti_pkg::BR_WAIT_OUT: pc_next = slot_free ? ctl.target : pc_q;
			default:              pc_next = eti_pkg::STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= eti_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign pc = pc_q;

endmodule

`default_nettype wire

// ===== rtl/core/eti_datapath.sv =====
// ----------------------------------------------------------------------------
// eti_datapath
// Iterate registers, shared signed multiplier, bailout compare and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module eti_datapath #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS = 28
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  eti_pkg::dp_op_t                         op,
	input  wire                                     load,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    point_re,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    point_im,
	input  wire                                     julia_mode,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    julia_c_re,
	input  wire signed [eti_pkg::POINT_BITS-1:0]    julia_c_im,
	input  wire        [COUNT_BITS-1:0]             max_iterations,
	output eti_pkg::dp_status_t                     status,
	output logic       [COUNT_BITS-1:0]             count
);

	// z needs six integer bits after an update plus room for a full 32-bit c.
	localparam int ZW0 = (FRAC_BITS + 7 > eti_pkg::POINT_BITS) ? FRAC_BITS + 7
		: eti_pkg::POINT_BITS;
	localparam int ZW = ZW0 + 1;
	// Multiplier operands hold values up to 5.0 in magnitude whenever the product is used.
	localparam int MW = FRAC_BITS + 4;
	localparam int PW = 2 * MW;

	localparam logic signed [ZW-1:0] FIVE = ZW'(5) << FRAC_BITS;
	localparam logic signed [PW-1:0] LIMIT = PW'(25) << (2 * FRAC_BITS);
	localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	logic signed [ZW-1:0] x_q, y_q;
	logic signed [eti_pkg::POINT_BITS-1:0] cr_q, ci_q;
	logic [COUNT_BITS-1:0] n_q;
	logic signed [PW-1:0] p_xx_q, p_xy_q, p_yy_q;
	logic signed [PW-1:0] d_q, e_q;

	logic signed [MW-1:0] xs, ys, mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] sum;
	logic signed [PW-FRAC_BITS-1:0] d_rnd, e_rnd;

	assign xs = x_q[MW-1:0];
	assign ys = y_q[MW-1:0];
	assign mul_a = (op == eti_pkg::OP_MYY) ? ys : xs;
	assign mul_b = (op == eti_pkg::OP_MXX) ? xs : ys;
	assign prod = mul_a * mul_b;

	assign sum = p_xx_q + p_yy_q;
	assign d_rnd = d_q[PW-1:FRAC_BITS];
	assign e_rnd = e_q[PW-1:FRAC_BITS];

	assign status.stop = (n_q >= max_iterations) || (x_q > FIVE) || (x_q < -FIVE)
		|| (y_q > FIVE) || (y_q < -FIVE);
	assign status.escape = sum > LIMIT;
	assign count = n_q;

	always_ff @(posedge clk) begin
		unique case (op)
			eti_pkg::OP_LOAD: begin
				if (load) begin
					x_q  <= ZW'(point_re);
					y_q  <= ZW'(point_im);
					cr_q <= julia_mode ? julia_c_re : point_re;
					ci_q <= julia_mode ? julia_c_im : point_im;
				end
			end
			eti_pkg::OP_MXX: p_xx_q <= prod;
			eti_pkg::OP_MXY: p_xy_q <= prod;
			eti_pkg::OP_MYY: p_yy_q <= prod;
			eti_pkg::OP_PREP: begin
				d_q <= p_xx_q - p_yy_q + HALF;
				e_q <= (p_xy_q <<< 1) + HALF;
			end
			eti_pkg::OP_STEP: begin
				// Floor after the half bias gives round half up.
				x_q <= ZW'(d_rnd) + ZW'(cr_q);
				y_q <= ZW'(e_rnd) + ZW'(ci_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (op == eti_pkg::OP_LOAD && load) begin
			n_q <= '0;
		end else if (op == eti_pkg::OP_STEP) begin
			n_q <= n_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
